### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and held off during rst_n low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define KSM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be true at a clock edge out of reset
`define KSM_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define KSM_ASSERT(label, prop)
`define KSM_ASSERT_NEVER(label, cond)

`endif

`endif

### rtl/ksm_pkg.sv
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared types and constants of the key set membership table.
// ----------------------------------------------------------------------------
package ksm_pkg;

    localparam int KEY_W = 64;

    // item operation codes
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_HAS = 2'd1,
        CMD_DEL = 2'd2,
        CMD_NOP = 2'd3
    } cmd_e;

    // kind of walk the token is making down the chain
    typedef enum logic {
        PASS_PROBE = 1'b0,
        PASS_PLACE = 1'b1
    } pass_e;

    // token handed from cell to cell
    typedef struct packed {
        logic live;    // token is in this stage
        logic hit;     // a valid entry matched the key
        logic vacant;  // a free entry was seen
        logic placed;  // the key was written into a free entry
    } tok_t;

endpackage

### rtl/key_set_membership_table_unit.sv
// An item with a zero key or the unused command code gives its result in the
// cycle after it is accepted and never raises busy; any other item sends the
// token down the chain on a probe walk, and an add that inserts follows it
// with a place walk. busy drops in the cycle the result is shown, and the unit
// takes a new item only while busy is low. The token walks one entry per cycle
// down the cell chain. Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// key_set_membership_table_unit
// Fixed-size set of nonzero 64-bit keys with add, query and delete. A token
// walks the row of entry cells; adds of absent keys take the lowest free entry.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_set_membership_table_unit #(
    parameter int ENTRIES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                command,
    input  logic [ksm_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic                      was_present,
    output logic                      changed,
    output logic                      table_full
);
    import ksm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_PLACE = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    cmd_e             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic             launch_reg;
    logic             launch_next;
    logic             done_reg;
    logic             done_next;
    logic             was_present_reg;
    logic             was_present_next;
    logic             changed_reg;
    logic             changed_next;
    logic             table_full_reg;
    logic             table_full_next;
    logic             accept;
    pass_e            mode;
    tok_t             tok [ENTRIES+1];
    tok_t             tail;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign mode   = (state_reg == ST_PLACE) ? PASS_PLACE : PASS_PROBE;
    assign tail   = tok[ENTRIES];

    // token enters the head of the chain
    assign tok[0] = '{live: launch_reg, hit: 1'b0, vacant: 1'b0, placed: 1'b0};

    // row of entry cells
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        ksm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .mode    (mode),
            .cmd     (cmd_reg),
            .key     (key_reg),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        launch_next      = 1'b0;
        done_next        = 1'b0;
        was_present_next = 1'b0;
        changed_next     = 1'b0;
        table_full_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((key == '0) || (cmd_e'(command) == CMD_NOP))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (tail.live)
                begin
                    if ((cmd_reg == CMD_ADD) && !tail.hit && tail.vacant)
                    begin
                        launch_next = 1'b1;
                        state_next  = ST_PLACE;
                    end
                    else
                    begin
                        done_next        = 1'b1;
                        was_present_next = tail.hit;
                        changed_next     = (cmd_reg == CMD_DEL) && tail.hit;
                        table_full_next  = (cmd_reg == CMD_ADD) && !tail.hit;
                        state_next       = ST_IDLE;
                    end
                end
            end
            ST_PLACE:
            begin
                if (tail.live)
                begin
                    done_next    = 1'b1;
                    changed_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_e'(command);
            key_reg <= key;
        end
        was_present_reg <= was_present_next;
        changed_reg     <= changed_next;
        table_full_reg  <= table_full_next;
    end

    assign done        = done_reg;
    assign was_present = was_present_reg;
    assign changed     = changed_reg;
    assign table_full  = table_full_reg;

    `KSM_ASSERT(a_place_lands, ((state_reg == ST_PLACE) && tail.live) |-> tail.placed)
    `KSM_ASSERT(a_launch_busy, launch_reg |-> busy)
    `KSM_ASSERT(a_done_idle, done_reg |-> (state_reg == ST_IDLE))
    `KSM_ASSERT_NEVER(a_flags_exclusive, done_reg && changed_reg && table_full_reg)

endmodule

### rtl/ksm_cell.sv
// ----------------------------------------------------------------------------
// ksm_cell
// One table entry: a stored key with its valid bit, plus the token stage that
// hands the walk on to the next entry.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ksm_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ksm_pkg::pass_e            mode,
    input  ksm_pkg::cmd_e             cmd,
    input  logic [ksm_pkg::KEY_W-1:0] key,
    input  ksm_pkg::tok_t             tok_in,
    output ksm_pkg::tok_t             tok_out
);
    import ksm_pkg::*;

    logic [KEY_W-1:0] entry_key_reg;
    logic             valid_reg;
    logic             valid_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             match;
    logic             take;

    // compare on the probe walk, claim a free entry on the place walk
    always_comb
    begin
        match = tok_in.live && (mode == PASS_PROBE) && valid_reg
                && (entry_key_reg == key);
        take  = tok_in.live && (mode == PASS_PLACE) && !tok_in.placed && !valid_reg;

        tok_next        = tok_in;
        tok_next.hit    = tok_in.hit | match;
        tok_next.vacant = tok_in.vacant | (tok_in.live && (mode == PASS_PROBE) && !valid_reg);
        tok_next.placed = tok_in.placed | take;

        valid_next = valid_reg;
        if (match && (cmd == CMD_DEL))
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // stored key
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_key_reg <= key;
        end
    end

    assign tok_out = tok_reg;

    `KSM_ASSERT(a_fill_on_place, $rose(valid_reg) |-> $past(mode == PASS_PLACE))
    `KSM_ASSERT(a_fill_marks_token, $rose(valid_reg) |-> tok_reg.placed)
    `KSM_ASSERT(a_free_on_delete, $fell(valid_reg) |-> $past(cmd == CMD_DEL))

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for key_set_membership_table_unit. A directed table
// covers reset, zero keys, the unused command, extreme keys and slot reuse.
// It is followed by rounds of random items. Each round fills the table past
// capacity, then mixes add, query, delete and the unused command over a shared
// key pool. Every result is checked against a behavioral model of the set or,
// for typed directed rows, against the result written out in the table.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ksm_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_DIRECTED  = 22;
    localparam int N_ROUNDS    = 4;
    localparam int FILL_ITEMS  = ENTRIES + 6;
    localparam int MIX_ITEMS   = 190;
    localparam int POOL_SIZE   = 96;
    localparam int MAX_SHOWN   = 10;

    // result fields, packed as {was_present, changed, table_full}
    typedef struct packed {
        logic was_present;
        logic changed;
        logic table_full;
    } outcome_t;

    // one outstanding result with the item that caused it
    typedef struct {
        cmd_e        op;
        logic [63:0] k;
        outcome_t    res;
    } pending_t;

    // directed row: typed marks rows whose result is written out by hand
    typedef struct {
        cmd_e        op;
        logic [63:0] k;
        bit          typed;
        outcome_t    res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [63:0] key;
    logic        done;
    logic        was_present;
    logic        changed;
    logic        table_full;

    // model of the set
    logic [63:0] model_keys [ENTRIES];
    bit          model_valid [ENTRIES];

    pending_t    pending_outcomes [$];
    logic [63:0] key_pool [$];

    int unsigned mismatches = 0;
    int unsigned n_checked  = 0;
    int unsigned n_inserts  = 0;
    int unsigned n_removals = 0;
    int unsigned n_drops    = 0;
    int unsigned n_hits     = 0;
    int unsigned cycles     = 0;

    dir_row_t dir_rows [N_DIRECTED] = '{
        '{CMD_HAS, 64'h1,                  1'b1, 3'b000},  // empty after reset
        '{CMD_DEL, 64'h1,                  1'b1, 3'b000},
        '{CMD_ADD, 64'h0,                  1'b1, 3'b000},  // null key ignored
        '{CMD_HAS, 64'h0,                  1'b1, 3'b000},
        '{CMD_DEL, 64'h0,                  1'b1, 3'b000},
        '{CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'b010},
        '{CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'b100},  // already present
        '{CMD_HAS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'b100},
        '{CMD_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'b000},  // unused code
        '{CMD_ADD, 64'h1,                  1'b1, 3'b010},
        '{CMD_ADD, 64'h8000_0000_0000_0000, 1'b1, 3'b010},
        '{CMD_HAS, 64'h8000_0000_0000_0000, 1'b1, 3'b100},
        '{CMD_HAS, 64'h4000_0000_0000_0000, 1'b1, 3'b000},  // near miss
        '{CMD_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'b110},
        '{CMD_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'b000},
        '{CMD_HAS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'b000},
        '{CMD_ADD, 64'h5555_5555_5555_5555, 1'b0, 3'b000},  // reuses freed slot
        '{CMD_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 3'b000},
        '{CMD_DEL, 64'h1,                  1'b0, 3'b000},
        '{CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 3'b000},
        '{CMD_HAS, 64'h5555_5555_5555_5555, 1'b0, 3'b000},
        '{CMD_NOP, 64'h0,                  1'b1, 3'b000}
    };

    key_set_membership_table_unit #(
        .ENTRIES (ENTRIES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .key         (key),
        .done        (done),
        .was_present (was_present),
        .changed     (changed),
        .table_full  (table_full)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // apply one operation to the model set and return its result
    function automatic outcome_t apply_set_op(cmd_e op, logic [63:0] k);
        outcome_t r;
        int       hit;
        int       vacant;
        r      = '0;
        hit    = -1;
        vacant = -1;
        if (k == 64'h0 || op == CMD_NOP)
            return r;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (model_valid[i] && model_keys[i] == k)
                hit = i;
            if (!model_valid[i])
                vacant = i;
        end
        r.was_present = (hit >= 0);
        case (op)
            CMD_ADD:
            begin
                if (hit < 0 && vacant >= 0)
                begin
                    model_keys[vacant]  = k;
                    model_valid[vacant] = 1'b1;
                    r.changed           = 1'b1;
                end
                else if (hit < 0)
                    r.table_full = 1'b1;
            end
            CMD_DEL:
            begin
                if (hit >= 0)
                begin
                    model_valid[hit] = 1'b0;
                    r.changed        = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // idle gap before an item: mostly none or short, now and then long
    function automatic int unsigned pick_gap(bit no_idle);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one item, wait for it to be taken, record its expected result
    task automatic send_item(cmd_e op, logic [63:0] k, int unsigned gap, bit drain,
                             bit typed, outcome_t typed_res);
        pending_t entry;
        outcome_t predicted;
        if (gap > 0 || drain)
        begin
            @(negedge clk);
            start <= 1'b0;
            while (drain && pending_outcomes.size() != 0)
                @(posedge clk);
            if (gap > 1)
                repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        command <= op;
        key     <= k;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_set_op(op, k);
        entry.op  = op;
        entry.k   = k;
        entry.res = typed ? typed_res : predicted;
        pending_outcomes = {pending_outcomes, entry};
    endtask

    // key for a random item: mostly from the pool, some fresh, a few null
    function automatic logic [63:0] pick_key(cmd_e op);
        logic [63:0] k;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return 64'h0;
        if (roll < ((op == CMD_ADD) ? 95 : 80))
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        k = {$urandom, $urandom};
        // fresh keys that get added join the pool so they can be deleted later
        if (op == CMD_ADD && k != 64'h0)
            key_pool = {key_pool, k};
        return k;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        pending_t   exp_item;
        outcome_t   got;
        if (rst_n && done)
        begin
            got = {was_present, changed, table_full};
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("[%0t] unexpected result: present=%b changed=%b full=%b",
                             $realtime, was_present, changed, table_full);
            end
            else
            begin
                exp_item = pending_outcomes.pop_front();
                n_checked++;
                if (got.was_present !== exp_item.res.was_present
                    || got.changed !== exp_item.res.changed
                    || got.table_full !== exp_item.res.table_full)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $write("[%0t] mismatch op=%s key=%h: ",
                               $realtime, exp_item.op.name(), exp_item.k);
                        $display("present %b/%b changed %b/%b full %b/%b (exp/got)",
                                 exp_item.res.was_present, got.was_present,
                                 exp_item.res.changed, got.changed,
                                 exp_item.res.table_full, got.table_full);
                    end
                end
                if (got.changed && exp_item.op == CMD_ADD)
                    n_inserts++;
                if (got.changed && exp_item.op == CMD_DEL)
                    n_removals++;
                if (got.table_full)
                    n_drops++;
                if (got.was_present)
                    n_hits++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_outcomes.size());
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        cmd_e        op;
        int unsigned roll;
        int unsigned offset;
        bit          no_idle;
        rst_n   = 1'b0;
        start   = 1'b0;
        command = CMD_NOP;
        key     = 64'h0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            model_keys[i]  = 64'h0;
            model_valid[i] = 1'b0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool = {key_pool, ({$urandom, $urandom} | 64'h1)};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].k, pick_gap(1'b0), 1'b0,
                      dir_rows[i].typed, dir_rows[i].res);

        // random rounds: overfill from the pool, then a mixed workload
        for (int r = 0; r < N_ROUNDS; r++)
        begin
            offset = $urandom_range(0, key_pool.size() - 1);
            for (int i = 0; i < FILL_ITEMS; i++)
                send_item(CMD_ADD, key_pool[(offset + i) % key_pool.size()],
                          pick_gap(r == 2), (i == 0), 1'b0, '0);
            no_idle = 1'b0;
            for (int i = 0; i < MIX_ITEMS; i++)
            begin
                if (i % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    op = CMD_ADD;
                else if (roll < 60)
                    op = CMD_HAS;
                else if (roll < 97)
                    op = CMD_DEL;
                else
                    op = CMD_NOP;
                send_item(op, pick_key(op), pick_gap(no_idle), (i == MIX_ITEMS / 2),
                          1'b0, '0);
            end
        end

        // drain and let any late result show up
        @(negedge clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (2 * ENTRIES + 4) @(posedge clk);

        $display("checked %0d results: %0d inserts, %0d removals, %0d full drops, %0d hits",
                 n_checked, n_inserts, n_removals, n_drops, n_hits);
        $display("%0d mismatches over %0d cycles", mismatches, cycles);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### key_set_membership_table_unit.f
+incdir+rtl
rtl/ksm_pkg.sv
rtl/ksm_cell.sv
rtl/key_set_membership_table_unit.sv
test/testbench.sv
